>>> sv/drmt_pkg.sv
// Shared types and codes for the dirty rectangle merge tracker.
`timescale 1ns / 1ps

package drmt_pkg;

    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] STS_MERGED    = 3'd0;
    localparam logic [STATUS_W-1:0] STS_APPENDED  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_IGNORED   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_DRAIN     = 3'd4;
    localparam logic [STATUS_W-1:0] STS_FULL_COPY = 3'd5;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd6;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } probe_ctl_t;

endpackage

>>> sv/drmt_cell.sv
// One table entry of the tracker: touch test, merge, append write and drain shift.
`timescale 1ns / 1ps

module drmt_cell #(
    parameter int CW  = 11,
    parameter int SW  = 5,
    parameter int IDX = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   active,
    input  drmt_pkg::probe_ctl_t   probe_in_ctl,
    input  logic [SW-1:0]          probe_in_slot,
    input  logic [4*CW-1:0]        probe_rect,
    input  logic                   wr_en,
    input  logic                   shift_en,
    input  logic [4*CW-1:0]        shift_in,
    output logic [4*CW-1:0]        entry,
    output drmt_pkg::probe_ctl_t   probe_out_ctl,
    output logic [SW-1:0]          probe_out_slot
);

    logic [4*CW-1:0]      entry_reg;
    logic [4*CW-1:0]      entry_next;
    drmt_pkg::probe_ctl_t ctl_reg;
    drmt_pkg::probe_ctl_t ctl_next;
    logic [SW-1:0]        slot_reg;
    logic [SW-1:0]        slot_next;

    logic [CW-1:0] d_x1, d_y1, d_x2, d_y2;
    logic [CW-1:0] n_x1, n_y1, n_x2, n_y2;
    logic          touch;
    logic          merge;

    assign d_x1 = entry_reg[4*CW-1 -: CW];
    assign d_y1 = entry_reg[3*CW-1 -: CW];
    assign d_x2 = entry_reg[2*CW-1 -: CW];
    assign d_y2 = entry_reg[CW-1 -: CW];
    assign n_x1 = probe_rect[4*CW-1 -: CW];
    assign n_y1 = probe_rect[3*CW-1 -: CW];
    assign n_x2 = probe_rect[2*CW-1 -: CW];
    assign n_y2 = probe_rect[CW-1 -: CW];

    always_comb
    begin
        touch = !((({1'b0, d_x2} + 1'b1) < {1'b0, n_x1}) ||
                  (({1'b0, n_x2} + 1'b1) < {1'b0, d_x1}) ||
                  (({1'b0, d_y2} + 1'b1) < {1'b0, n_y1}) ||
                  (({1'b0, n_y2} + 1'b1) < {1'b0, d_y1}));
        merge = active && probe_in_ctl.valid && !probe_in_ctl.hit && touch;
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (shift_en)
        begin
            entry_next = shift_in;
        end
        else if (wr_en)
        begin
            entry_next = probe_rect;
        end
        else if (merge)
        begin
            entry_next = {(n_x1 < d_x1) ? n_x1 : d_x1,
                          (n_y1 < d_y1) ? n_y1 : d_y1,
                          (n_x2 > d_x2) ? n_x2 : d_x2,
                          (n_y2 > d_y2) ? n_y2 : d_y2};
        end
        ctl_next.valid = probe_in_ctl.valid;
        ctl_next.hit   = probe_in_ctl.hit | merge;
        slot_next      = merge ? SW'(IDX) : probe_in_slot;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        slot_reg  <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    assign entry          = entry_reg;
    assign probe_out_ctl  = ctl_reg;
    assign probe_out_slot = slot_reg;

endmodule

>>> sv/dirty_rect_merge_tracker_unit.sv
// Top level of the dirty rectangle merge tracker: control, cell chain and result register.
`timescale 1ns / 1ps

// Record transfers send a probe down a chain of MAX_RECTS cells, one cell per
// cycle; the first stored rectangle that overlaps or abuts absorbs it, and if
// none does it is appended, or the table is flagged overflowed when full. The
// next item is taken once a record's result is in the output register. Drains
// shift the chain toward cell 0 and deliver one rectangle per cycle while the
// output is not stalled. Drains of an empty or overflowed table and records
// after overflow give their single result straight from the idle state. The
// table needs no clearing pass after reset.
module dirty_rect_merge_tracker_unit #(
    parameter int MAX_RECTS  = 32,
    parameter int COORD_BITS = 11
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic                                       kind,
    input  logic [COORD_BITS-1:0]                      left_x,
    input  logic [COORD_BITS-1:0]                      top_y,
    input  logic [COORD_BITS-1:0]                      right_x,
    input  logic [COORD_BITS-1:0]                      bottom_y,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic [drmt_pkg::STATUS_W-1:0]              status,
    output logic [((MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1)-1:0] slot,
    output logic [$clog2(MAX_RECTS + 1)-1:0]           used,
    output logic [COORD_BITS-1:0]                      out_x,
    output logic [COORD_BITS-1:0]                      out_y,
    output logic [COORD_BITS:0]                        out_width,
    output logic [COORD_BITS:0]                        out_height,
    output logic                                       last
);

    localparam int CW  = COORD_BITS;
    localparam int SZW = COORD_BITS + 1;
    localparam int RW  = 4 * COORD_BITS;
    localparam int SW  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int UW  = $clog2(MAX_RECTS + 1);

    drmt_pkg::state_t state_reg, state_next;

    logic [UW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic           start_reg, start_next;
    logic [SW-1:0]  drain_idx_reg, drain_idx_next;
    logic           hit_reg, hit_next;
    logic [SW-1:0]  hit_slot_reg, hit_slot_next;
    logic [RW-1:0]  q_reg, q_next;

    logic                          out_valid_reg, out_valid_next;
    logic [drmt_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [SW-1:0]                 slot_reg, slot_next;
    logic [UW-1:0]                 used_reg, used_next;
    logic [CW-1:0]                 x_reg, x_next;
    logic [CW-1:0]                 y_reg, y_next;
    logic [SZW-1:0]                w_reg, w_next;
    logic [SZW-1:0]                h_reg, h_next;
    logic                          last_reg, last_next;

    logic out_free;
    logic in_fire;
    logic out_load;
    logic append;
    logic shift_en;
    logic drain_last;

    drmt_pkg::probe_ctl_t probe_ctl  [MAX_RECTS+1];
    logic [SW-1:0]        probe_slot [MAX_RECTS+1];
    logic [RW-1:0]        entry      [MAX_RECTS];
    logic [MAX_RECTS:0]   probe_vld;

    logic [CW-1:0] head_x1, head_y1, head_x2, head_y2;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != drmt_pkg::S_IDLE) || !out_free;
    assign in_fire  = in_valid && !in_stall;

    assign head_x1 = entry[0][RW-1 -: CW];
    assign head_y1 = entry[0][3*CW-1 -: CW];
    assign head_x2 = entry[0][2*CW-1 -: CW];
    assign head_y2 = entry[0][CW-1 -: CW];

    assign drain_last = ((UW'(drain_idx_reg) + 1'b1) == count_reg);

    // Cell chain
    assign probe_ctl[0].valid = start_reg;
    assign probe_ctl[0].hit   = 1'b0;
    assign probe_slot[0]      = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RECTS; gi++)
        begin : g_cell
            logic [RW-1:0] shift_src;

            if (gi == MAX_RECTS - 1)
            begin : g_tail
                assign shift_src = entry[gi];
            end
            else
            begin : g_body
                assign shift_src = entry[gi+1];
            end

            drmt_cell #(
                .CW  (CW),
                .SW  (SW),
                .IDX (gi)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .active         (UW'(gi) < count_reg),
                .probe_in_ctl   (probe_ctl[gi]),
                .probe_in_slot  (probe_slot[gi]),
                .probe_rect     (q_reg),
                .wr_en          (append && (count_reg == UW'(gi))),
                .shift_en       (shift_en),
                .shift_in       (shift_src),
                .entry          (entry[gi]),
                .probe_out_ctl  (probe_ctl[gi+1]),
                .probe_out_slot (probe_slot[gi+1])
            );
        end

        for (gi = 0; gi <= MAX_RECTS; gi++)
        begin : g_vld
            assign probe_vld[gi] = probe_ctl[gi].valid;
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            drmt_pkg::S_IDLE:
            begin
                if (in_fire && !ovf_reg)
                begin
                    if (kind == drmt_pkg::KIND_RECORD)
                    begin
                        state_next = drmt_pkg::S_SCAN;
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = drmt_pkg::S_DRAIN;
                    end
                end
            end
            drmt_pkg::S_SCAN:
            begin
                if (probe_ctl[MAX_RECTS].valid)
                begin
                    state_next = drmt_pkg::S_FINISH;
                end
            end
            drmt_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = drmt_pkg::S_IDLE;
                end
            end
            drmt_pkg::S_DRAIN:
            begin
                if (out_free && drain_last)
                begin
                    state_next = drmt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = drmt_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        start_next     = 1'b0;
        drain_idx_next = drain_idx_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        q_next         = q_reg;
        out_load       = 1'b0;
        append         = 1'b0;
        shift_en       = 1'b0;
        status_next    = drmt_pkg::STS_MERGED;
        slot_next      = '0;
        used_next      = '0;
        x_next         = '0;
        y_next         = '0;
        w_next         = '0;
        h_next         = '0;
        last_next      = 1'b1;

        unique case (state_reg)
            drmt_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind == drmt_pkg::KIND_DRAIN)
                    begin
                        drain_idx_next = '0;
                        if (ovf_reg)
                        begin
                            out_load    = 1'b1;
                            status_next = drmt_pkg::STS_FULL_COPY;
                            w_next      = {1'b1, {CW{1'b0}}};
                            h_next      = {1'b1, {CW{1'b0}}};
                            count_next  = '0;
                            ovf_next    = 1'b0;
                        end
                        else if (count_reg == '0)
                        begin
                            out_load    = 1'b1;
                            status_next = drmt_pkg::STS_EMPTY;
                        end
                    end
                    else if (ovf_reg)
                    begin
                        out_load    = 1'b1;
                        status_next = drmt_pkg::STS_IGNORED;
                        used_next   = count_reg;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        q_next     = {left_x, top_y, right_x, bottom_y};
                    end
                end
            end
            drmt_pkg::S_SCAN:
            begin
                if (probe_ctl[MAX_RECTS].valid)
                begin
                    hit_next      = probe_ctl[MAX_RECTS].hit;
                    hit_slot_next = probe_slot[MAX_RECTS];
                end
            end
            drmt_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (hit_reg)
                    begin
                        status_next = drmt_pkg::STS_MERGED;
                        slot_next   = hit_slot_reg;
                        used_next   = count_reg;
                    end
                    else if (count_reg < UW'(MAX_RECTS))
                    begin
                        append      = 1'b1;
                        status_next = drmt_pkg::STS_APPENDED;
                        slot_next   = count_reg[SW-1:0];
                        count_next  = count_reg + 1'b1;
                        used_next   = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next    = 1'b1;
                        status_next = drmt_pkg::STS_OVERFLOW;
                        used_next   = count_reg;
                    end
                end
            end
            drmt_pkg::S_DRAIN:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    shift_en       = 1'b1;
                    status_next    = drmt_pkg::STS_DRAIN;
                    slot_next      = drain_idx_reg;
                    x_next         = head_x1;
                    y_next         = head_y1;
                    w_next         = {1'b0, head_x2} - {1'b0, head_x1} + 1'b1;
                    h_next         = {1'b0, head_y2} - {1'b0, head_y1} + 1'b1;
                    last_next      = drain_last;
                    drain_idx_next = drain_idx_reg + 1'b1;
                    if (drain_last)
                    begin
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drmt_pkg::S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drain_idx_reg <= drain_idx_next;
        hit_reg       <= hit_next;
        hit_slot_reg  <= hit_slot_next;
        q_reg         <= q_next;
        if (out_load)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            used_reg   <= used_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            w_reg      <= w_next;
            h_reg      <= h_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot       = slot_reg;
    assign used       = used_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign out_width  = w_reg;
    assign out_height = h_reg;
    assign last       = last_reg;

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == UW'(MAX_RECTS)))
        else $error("overflow flag set with table not full");

    a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drmt_pkg::S_SCAN) |-> $onehot(probe_vld))
        else $error("scan without exactly one probe in the chain");

    a_no_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drmt_pkg::S_IDLE || state_reg == drmt_pkg::S_DRAIN)
        |-> (probe_vld == '0))
        else $error("probe in the chain outside a scan");

    a_drain_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drmt_pkg::S_DRAIN) |-> (count_reg != '0 && !ovf_reg))
        else $error("drain walk on empty or overflowed table");

endmodule
